/* hw/rtl/dual_screen_key_controller_assert.svh */
// ----------------------------------------------------------------------------
// Dual screen key controller - assertion macros
// Property macros shared by the controller RTL. Each expects aclk and
// aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef DUAL_SCREEN_KEY_CONTROLLER_ASSERT_SVH
`define DUAL_SCREEN_KEY_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DSK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dsk_pkg.sv */
// ----------------------------------------------------------------------------
// Dual screen key controller package
// Field widths, opcode and register codes, word and state types.
// ----------------------------------------------------------------------------
package dsk_pkg;

    localparam int TIME_W     = 32;
    localparam int WIN_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OPCODE_W   = 3;
    localparam int KEY_W      = 2;
    localparam int REQ_W      = 3;

    localparam logic [WIN_W-1:0] RST_LONG_PRESS_MS  = 16'd800;
    localparam logic [WIN_W-1:0] RST_PWR_LONG_MS    = 16'd450;
    localparam logic [WIN_W-1:0] RST_DOUBLE_MS      = 16'd300;
    localparam logic             RST_SINGLE_CLEARS  = 1'b0;
    localparam logic             RST_MIRROR_IN_LCD  = 1'b0;
    localparam logic             RST_INITIAL_SCREEN = 1'b0;
    localparam logic             RST_INITIAL_AWAKE  = 1'b1;

    localparam logic SCR_LCD  = 1'b0;
    localparam logic SCR_EINK = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_EKEY      = 3'd0,
        OP_PWR_KEY   = 3'd1,
        OP_TICK      = 3'd2,
        OP_REQUEST   = 3'd3,
        OP_SET_AWAKE = 3'd4
    } dsk_opcode_t;

    typedef enum logic [KEY_W-1:0] {
        KEY_RELEASE = 2'd0,
        KEY_PRESS   = 2'd1,
        KEY_REPEAT  = 2'd2
    } dsk_key_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_EINK   = 3'd0,
        REQ_LCD    = 3'd1,
        REQ_TOGGLE = 3'd2,
        REQ_CLEAR  = 3'd3
    } dsk_req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS    = 3'd0,
        CFG_PWR_LONG      = 3'd1,
        CFG_DOUBLE        = 3'd2,
        CFG_SINGLE_CLEARS = 3'd3,
        CFG_MIRROR_IN_LCD = 3'd4,
        CFG_INIT_SCREEN   = 3'd5,
        CFG_INIT_AWAKE    = 3'd6
    } dsk_cfg_idx_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KEY_W-1:0]    key_value;
        logic [TIME_W-1:0]   time_ms;
        logic [REQ_W-1:0]    request_code;
        logic                awake_flag;
    } dsk_item_t;

    typedef struct packed {
        logic screen_change;
        logic new_screen;
        logic wake;
        logic sleep;
        logic clear;
        logic inject_press;
        logic inject_release;
        logic power_grabbed;
        logic touch_grabbed;
        logic lcd_blank;
        logic mirror_on;
    } dsk_result_t;

    typedef struct packed {
        logic              screen;
        logic              awake;
        logic              ekey_down;
        logic [TIME_W-1:0] ekey_press_time;
        logic              ekey_long_done;
        logic              ekey_double_done;
        logic              ekey_pending;
        logic [TIME_W-1:0] ekey_pending_time;
        logic              pwr_down;
        logic [TIME_W-1:0] pwr_press_time;
        logic              pwr_injected;
        logic              pwr_grabbed_at_press;
    } dsk_state_t;

    localparam dsk_state_t STATE_RESET = '{
        screen:               RST_INITIAL_SCREEN,
        awake:                RST_INITIAL_AWAKE,
        ekey_down:            1'b0,
        ekey_press_time:      '0,
        ekey_long_done:       1'b0,
        ekey_double_done:     1'b0,
        ekey_pending:         1'b0,
        ekey_pending_time:    '0,
        pwr_down:             1'b0,
        pwr_press_time:       '0,
        pwr_injected:         1'b0,
        pwr_grabbed_at_press: 1'b0
    };

endpackage

/* hw/rtl/dual_screen_key_controller.sv */
// ----------------------------------------------------------------------------
// Dual screen key controller
// Chooses the active screen (LCD or e-ink) from key, tick, request and set-awake
// words, detects long and double presses, and issues wake, sleep, clear and power
// key inject actions.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                         Flow      Width
//  -------   ----------------------------  --------  ------------------------
//  input     s_valid/s_ready, s_*          in        opcode, key, time, req, awake
//  result    m_valid/m_ready, m_*          out       11 one-bit flags
//  config    cfg_wr_en, cfg_index, cfg_data in       16 bit data, no wait
//
//  One word per cycle sustained while m_ready stays high. A word accepted into
//  the input register is evaluated against the controller state and loaded
//  into the result register, which drives m_valid.
//  The state update and the result load happen together, so consecutive
//  words see each other's effects with no bubble.
//  If the result register is full and not taken, the input register holds
//  the next word; s_ready drops only when both are full.
//  aresetn is synchronous and active low; it loads the register defaults,
//  screen from RST_INITIAL_SCREEN and the awake flag from RST_INITIAL_AWAKE.
//  Writing initial_screen or initial_awake also reloads screen or awake.
//
module dual_screen_key_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dsk_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [dsk_pkg::KEY_W-1:0]     s_key_value,
    input  logic [dsk_pkg::TIME_W-1:0]    s_time_ms,
    input  logic [dsk_pkg::REQ_W-1:0]     s_request_code,
    input  logic                          s_awake_flag,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_screen_change,
    output logic                          m_new_screen,
    output logic                          m_wake,
    output logic                          m_sleep,
    output logic                          m_clear,
    output logic                          m_inject_press,
    output logic                          m_inject_release,
    output logic                          m_power_grabbed,
    output logic                          m_touch_grabbed,
    output logic                          m_lcd_blank,
    output logic                          m_mirror_on,
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [dsk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsk_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dsk_pkg::*;

    // configuration registers
    logic [WIN_W-1:0] long_press_ms_reg;
    logic [WIN_W-1:0] pwr_long_ms_reg;
    logic [WIN_W-1:0] double_ms_reg;
    logic             single_clears_reg;
    logic             mirror_in_lcd_reg;

    // pipeline: input register -> evaluate -> result register
    logic        in_valid_reg;
    dsk_item_t   in_reg;
    logic        out_valid_reg;
    dsk_result_t out_reg;
    logic        advance;

    dsk_state_t  state_reg;
    dsk_state_t  state_next;
    dsk_result_t res_next;

    // elapsed-time compares, wrapping 32 bit difference
    logic [TIME_W-1:0] ekey_elapsed;
    logic [TIME_W-1:0] pend_elapsed;
    logic [TIME_W-1:0] pwr_elapsed;
    logic              ekey_long_hit;
    logic              pend_hit;
    logic              pwr_hit;

    // tick outcome, shared by the tick opcode and key repeats
    logic t_long;
    logic t_pend;
    logic t_pwr;
    logic eink_awake;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign ekey_elapsed  = in_reg.time_ms - state_reg.ekey_press_time;
    assign pend_elapsed  = in_reg.time_ms - state_reg.ekey_pending_time;
    assign pwr_elapsed   = in_reg.time_ms - state_reg.pwr_press_time;
    assign ekey_long_hit = ekey_elapsed >= {{(TIME_W-WIN_W){1'b0}}, long_press_ms_reg};
    assign pend_hit      = pend_elapsed >= {{(TIME_W-WIN_W){1'b0}}, double_ms_reg};
    assign pwr_hit       = pwr_elapsed  >= {{(TIME_W-WIN_W){1'b0}}, pwr_long_ms_reg};

    assign eink_awake = (state_reg.screen == SCR_EINK) && state_reg.awake;

    assign t_long = state_reg.ekey_down && !state_reg.ekey_long_done &&
                    !state_reg.ekey_double_done && ekey_long_hit;
    assign t_pend = state_reg.ekey_pending && !state_reg.ekey_down && pend_hit;
    assign t_pwr  = state_reg.pwr_down && state_reg.pwr_grabbed_at_press &&
                    !state_reg.pwr_injected && pwr_hit;

    // one word's worth of control
    always_comb begin
        logic do_tick;
        do_tick    = 1'b0;
        state_next = state_reg;
        res_next   = '0;

        unique case (in_reg.opcode)
            OP_EKEY: begin
                unique case (in_reg.key_value)
                    KEY_REPEAT: begin
                        do_tick = 1'b1;
                    end
                    KEY_PRESS: begin
                        if (!state_reg.ekey_down) begin
                            state_next.ekey_down        = 1'b1;
                            state_next.ekey_press_time  = in_reg.time_ms;
                            state_next.ekey_long_done   = 1'b0;
                            // press inside the double press window
                            state_next.ekey_double_done = state_reg.ekey_pending;
                            state_next.ekey_pending     = 1'b0;
                            res_next.clear              = state_reg.ekey_pending;
                        end
                    end
                    default: begin
                        // release (the unused key code counts as release)
                        if (state_reg.ekey_down) begin
                            state_next.ekey_down = 1'b0;
                            if (!state_reg.ekey_long_done && !state_reg.ekey_double_done) begin
                                if (ekey_long_hit) begin
                                    res_next.clear = 1'b1;
                                end else if (state_reg.screen == SCR_LCD) begin
                                    res_next.screen_change = 1'b1;
                                    res_next.new_screen    = SCR_EINK;
                                    res_next.wake          = 1'b1;
                                end else if (!state_reg.awake) begin
                                    res_next.wake = 1'b1;
                                end else if (double_ms_reg == '0) begin
                                    res_next.clear = single_clears_reg;
                                    res_next.sleep = !single_clears_reg;
                                end else begin
                                    state_next.ekey_pending      = 1'b1;
                                    state_next.ekey_pending_time = in_reg.time_ms;
                                end
                            end
                        end
                    end
                endcase
            end
            OP_PWR_KEY: begin
                unique case (in_reg.key_value)
                    KEY_REPEAT: begin
                        do_tick = 1'b1;
                    end
                    KEY_PRESS: begin
                        if (!state_reg.pwr_down) begin
                            state_next.pwr_down             = 1'b1;
                            state_next.pwr_press_time       = in_reg.time_ms;
                            state_next.pwr_injected         = 1'b0;
                            state_next.pwr_grabbed_at_press = eink_awake;
                            // power press on a sleeping e-ink hands over to the LCD
                            if (state_reg.screen == SCR_EINK && !state_reg.awake) begin
                                res_next.screen_change = 1'b1;
                                res_next.new_screen    = SCR_LCD;
                            end
                        end
                    end
                    default: begin
                        if (state_reg.pwr_down) begin
                            state_next.pwr_down = 1'b0;
                            if (state_reg.pwr_grabbed_at_press) begin
                                if (state_reg.pwr_injected) begin
                                    res_next.inject_release = 1'b1;
                                    state_next.pwr_injected = 1'b0;
                                end else begin
                                    res_next.screen_change = 1'b1;
                                    res_next.new_screen    = SCR_LCD;
                                end
                            end
                        end
                    end
                endcase
            end
            OP_TICK: begin
                do_tick = 1'b1;
            end
            OP_REQUEST: begin
                unique case (in_reg.request_code)
                    REQ_EINK: begin
                        if (state_reg.screen != SCR_EINK) begin
                            res_next.screen_change = 1'b1;
                            res_next.new_screen    = SCR_EINK;
                            res_next.wake          = !state_reg.awake;
                        end
                    end
                    REQ_LCD: begin
                        if (state_reg.screen != SCR_LCD) begin
                            res_next.screen_change = 1'b1;
                            res_next.new_screen    = SCR_LCD;
                            res_next.wake          = !state_reg.awake;
                        end
                    end
                    REQ_TOGGLE: begin
                        res_next.screen_change = 1'b1;
                        res_next.new_screen    = !state_reg.screen;
                        res_next.wake          = !state_reg.awake;
                    end
                    REQ_CLEAR: begin
                        res_next.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            OP_SET_AWAKE: begin
                state_next.awake = in_reg.awake_flag;
            end
            default: begin
            end
        endcase

        if (do_tick) begin
            state_next.ekey_long_done = state_reg.ekey_long_done || t_long;
            state_next.ekey_pending   = state_reg.ekey_pending && !t_pend;
            state_next.pwr_injected   = state_reg.pwr_injected || t_pwr;
            res_next.clear        = t_long || (t_pend && eink_awake && single_clears_reg);
            res_next.sleep        = t_pend && eink_awake && !single_clears_reg;
            res_next.inject_press = t_pwr;
        end

        if (res_next.screen_change) begin
            state_next.screen = res_next.new_screen;
        end

        // status after this word
        res_next.power_grabbed = (state_next.screen == SCR_EINK) && state_next.awake;
        res_next.touch_grabbed = (state_next.screen == SCR_EINK);
        res_next.lcd_blank     = (state_next.screen == SCR_EINK);
        res_next.mirror_on     = (state_next.screen == SCR_EINK) || mirror_in_lcd_reg;
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg         <= STATE_RESET;
            long_press_ms_reg <= RST_LONG_PRESS_MS;
            pwr_long_ms_reg   <= RST_PWR_LONG_MS;
            double_ms_reg     <= RST_DOUBLE_MS;
            single_clears_reg <= RST_SINGLE_CLEARS;
            mirror_in_lcd_reg <= RST_MIRROR_IN_LCD;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                state_reg <= state_next;
            end

            // writes must arrive only while idle; the block does not enforce this
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_LONG_PRESS:    long_press_ms_reg <= cfg_data[WIN_W-1:0];
                    CFG_PWR_LONG:      pwr_long_ms_reg   <= cfg_data[WIN_W-1:0];
                    CFG_DOUBLE:        double_ms_reg     <= cfg_data[WIN_W-1:0];
                    CFG_SINGLE_CLEARS: single_clears_reg <= cfg_data[0];
                    CFG_MIRROR_IN_LCD: mirror_in_lcd_reg <= cfg_data[0];
                    CFG_INIT_SCREEN:   state_reg.screen  <= cfg_data[0];
                    CFG_INIT_AWAKE:    state_reg.awake   <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= '{opcode:       s_opcode,
                        key_value:    s_key_value,
                        time_ms:      s_time_ms,
                        request_code: s_request_code,
                        awake_flag:   s_awake_flag};
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_screen_change  = out_reg.screen_change;
    assign m_new_screen     = out_reg.new_screen;
    assign m_wake           = out_reg.wake;
    assign m_sleep          = out_reg.sleep;
    assign m_clear          = out_reg.clear;
    assign m_inject_press   = out_reg.inject_press;
    assign m_inject_release = out_reg.inject_release;
    assign m_power_grabbed  = out_reg.power_grabbed;
    assign m_touch_grabbed  = out_reg.touch_grabbed;
    assign m_lcd_blank      = out_reg.lcd_blank;
    assign m_mirror_on      = out_reg.mirror_on;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "dual_screen_key_controller_assert.svh"

    `DSK_ASSERT_NOW(a_switch_applied, m_valid && m_screen_change, m_touch_grabbed == m_new_screen, "screen switch not reflected in status")
    `DSK_ASSERT_NOW(a_no_target_idle, m_valid && !m_screen_change, !m_new_screen, "new_screen set without a switch")
    `DSK_ASSERT_NOW(a_grab_eink, m_valid && m_power_grabbed, m_touch_grabbed, "power grabbed outside e-ink")
    `DSK_ASSERT_NOW(a_wake_sleep, m_valid, !(m_wake && m_sleep), "wake and sleep in one word")
    `DSK_ASSERT_NEXT(a_advance_loads, advance, out_valid_reg, "evaluated word not held in result register")
    `DSK_ASSERT_NOW(a_ready_empty, !in_valid_reg, s_ready, "input stall with empty input register")

endmodule
